>>> rtl/dmc_pkg.sv
// Shared types, constants and control structs for the direct-mapped read cache.
package dmc_pkg;

  localparam int LINE_COUNT = 8;
  localparam int LINE_BYTES = 16;
  localparam int MEM_BYTES  = 4096;

  localparam int ADDR_W   = 12;
  localparam int WORD_W   = $clog2(LINE_BYTES);
  localparam int LINE_W   = $clog2(LINE_COUNT);
  localparam int TAG_W    = ADDR_W - WORD_W - LINE_W;
  localparam int BLOCK_W  = ADDR_W - WORD_W;
  localparam int MEM_AW   = $clog2(MEM_BYTES);
  localparam int LDATA_AW = LINE_W + WORD_W;
  localparam int BYTE_W   = 8;
  localparam int CNT_W    = 32;
  localparam int PEN_W    = 8;

  localparam int APB_DW = 32;
  localparam int APB_AW = 3;

  // Register index, taken from paddr above the byte offset
  localparam logic REG_MISS_PENALTY = 1'b0;

  localparam logic [PEN_W-1:0] PENALTY_RESET = 8'd10;

  typedef struct packed {
    logic              op;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] load_byte;
  } dmc_in_t;

  typedef struct packed {
    logic              hit;
    logic [BYTE_W-1:0] read_byte;
    logic [TAG_W-1:0]  tag_field;
    logic [LINE_W-1:0] line_field;
    logic [WORD_W-1:0] word_field;
    logic [CNT_W-1:0]  access_total;
    logic [CNT_W-1:0]  miss_total;
    logic [CNT_W-1:0]  time_total;
  } dmc_out_t;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_FILL,
    ST_LINE_RD,
    ST_RESP
  } dmc_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take;     // capture the request address
    logic load;     // write one backing-memory byte
    logic lookup;   // compare tag, start fill read on a miss
    logic fill;     // move one byte from backing memory into the line
    logic line_rd;  // read the addressed byte from the line store
    logic commit;   // update counters and load the output register
  } dmc_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic in_read;
    logic tag_hit;
    logic fill_last;
    logic out_free;
  } dmc_sts_t;

endpackage

>>> rtl/dmc_ctrl.sv
// Controller state machine for the direct-mapped read cache.
module dmc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  dmc_pkg::dmc_sts_t sts,
  output dmc_pkg::dmc_cmd_t cmd
);
  import dmc_pkg::*;

  dmc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (sts.in_read == OP_READ) begin
            cmd.take  = 1'b1;
            state_nxt = ST_LOOKUP;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        if (sts.tag_hit) begin
          cmd.line_rd = 1'b1;
          state_nxt   = ST_RESP;
        end else begin
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        cmd.fill = 1'b1;
        if (sts.fill_last) begin
          state_nxt = ST_LINE_RD;
        end
      end
      ST_LINE_RD: begin
        cmd.line_rd = 1'b1;
        state_nxt   = ST_RESP;
      end
      ST_RESP: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/dmc_dpath.sv
// Datapath of the direct-mapped read cache: memories, tags, counters, output register.
module dmc_dpath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dmc_pkg::dmc_in_t             in_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dmc_pkg::APB_AW-1:0]   paddr,
  input  logic [dmc_pkg::APB_DW-1:0]   pwdata,
  output logic [dmc_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  output logic                         out_valid,
  input  logic                         out_stall,
  output dmc_pkg::dmc_out_t            out_data,
  input  dmc_pkg::dmc_cmd_t            cmd,
  output dmc_pkg::dmc_sts_t            sts
);
  import dmc_pkg::*;

  logic [ADDR_W-1:0] req_addr_r;
  logic              hit_r;
  logic [WORD_W-1:0] fill_cnt_r;

  logic [TAG_W-1:0]      tag_r [LINE_COUNT];
  logic [LINE_COUNT-1:0] tag_vld_r;

  logic [BYTE_W-1:0] backing_r  [MEM_BYTES];
  logic [BYTE_W-1:0] line_mem_r [LINE_COUNT*LINE_BYTES];
  logic [BYTE_W-1:0] bm_q_r;
  logic [BYTE_W-1:0] lm_q_r;

  logic [CNT_W-1:0] access_cnt_r, access_cnt_nxt;
  logic [CNT_W-1:0] miss_cnt_r, miss_cnt_nxt;
  logic [CNT_W-1:0] time_cnt_r, time_cnt_nxt;
  logic [PEN_W-1:0] penalty_r;

  logic     out_valid_r;
  dmc_out_t out_data_r;

  logic [TAG_W-1:0]  req_tag;
  logic [LINE_W-1:0] req_line;
  logic [WORD_W-1:0] req_word;
  logic              tag_hit;
  logic              fill_last;
  logic              out_free;
  logic              bm_rd_en;
  logic [WORD_W-1:0] bm_rd_off;
  logic [MEM_AW-1:0] bm_rd_addr;
  logic              cfg_wr;
  logic              cfg_sel;

  assign req_tag  = req_addr_r[ADDR_W-1 -: TAG_W];
  assign req_line = req_addr_r[WORD_W +: LINE_W];
  assign req_word = req_addr_r[WORD_W-1:0];

  assign tag_hit   = tag_vld_r[req_line] && (tag_r[req_line] == req_tag);
  assign fill_last = (fill_cnt_r == WORD_W'(LINE_BYTES - 1));
  assign out_free  = !out_valid_r || !out_stall;

  // Fetch block byte 0 on a miss, then one byte ahead of the write pointer
  assign bm_rd_en   = (cmd.lookup && !tag_hit) || cmd.fill;
  assign bm_rd_off  = cmd.fill ? WORD_W'(fill_cnt_r + 1'b1) : '0;
  assign bm_rd_addr = MEM_AW'({req_addr_r[ADDR_W-1:WORD_W], bm_rd_off});

  assign cfg_sel = (paddr[APB_AW-1:2] == REG_MISS_PENALTY);
  assign cfg_wr  = psel && penable && pwrite && pready && cfg_sel;
  assign pready  = 1'b1;
  assign prdata  = cfg_sel ? APB_DW'(penalty_r) : '0;

  assign access_cnt_nxt = access_cnt_r + CNT_W'(1);
  assign miss_cnt_nxt   = miss_cnt_r + CNT_W'(!hit_r);
  assign time_cnt_nxt   = time_cnt_r + CNT_W'(1) + (hit_r ? '0 : CNT_W'(penalty_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_vld_r    <= '0;
      access_cnt_r <= '0;
      miss_cnt_r   <= '0;
      time_cnt_r   <= '0;
      penalty_r    <= PENALTY_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        penalty_r <= pwdata[PEN_W-1:0];
      end
      if (cmd.fill && fill_last) begin
        tag_vld_r[req_line] <= 1'b1;
      end
      if (cmd.commit) begin
        access_cnt_r <= access_cnt_nxt;
        miss_cnt_r   <= miss_cnt_nxt;
        time_cnt_r   <= time_cnt_nxt;
        out_valid_r  <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      req_addr_r <= in_data.addr;
    end
    if (cmd.lookup) begin
      hit_r      <= tag_hit;
      fill_cnt_r <= '0;
    end else if (cmd.fill) begin
      fill_cnt_r <= WORD_W'(fill_cnt_r + 1'b1);
    end
    if (cmd.fill && fill_last) begin
      tag_r[req_line] <= req_tag;
    end
    if (cmd.commit) begin
      out_data_r.hit          <= hit_r;
      out_data_r.read_byte    <= lm_q_r;
      out_data_r.tag_field    <= req_tag;
      out_data_r.line_field   <= req_line;
      out_data_r.word_field   <= req_word;
      out_data_r.access_total <= access_cnt_nxt;
      out_data_r.miss_total   <= miss_cnt_nxt;
      out_data_r.time_total   <= time_cnt_nxt;
    end
  end

  // Backing memory: one port, written by loads, read by line fills
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      backing_r[in_data.addr[MEM_AW-1:0]] <= in_data.load_byte;
    end
    if (bm_rd_en) begin
      bm_q_r <= backing_r[bm_rd_addr];
    end
  end

  // Line store
  always_ff @(posedge clk) begin
    if (cmd.fill) begin
      line_mem_r[{req_line, fill_cnt_r}] <= bm_q_r;
    end
    if (cmd.line_rd) begin
      lm_q_r <= line_mem_r[{req_line, req_word}];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sts.in_read   = in_data.op;
  assign sts.tag_hit   = tag_hit;
  assign sts.fill_last = fill_last;
  assign sts.out_free  = out_free;

endmodule

>>> rtl/direct_mapped_cache_read.sv
// Top level of the direct-mapped read cache.
// A direct-mapped read cache of 8 lines of 16 bytes in front of a 4096-byte,
// byte-wide backing memory. A load request (op 0) writes one backing byte and
// is taken in the idle state with no result. A read request (op 1) splits its
// 12-bit address into a 5-bit tag, a 3-bit line index and a 4-bit byte offset
// and returns one result: the byte, the hit flag, the three address fields and
// the running access, miss and time counts. The block works on one read
// request at a time. A hit passes through lookup, then result. A miss also
// fills the line between the two: the fill copies the block one byte per
// cycle through the single port of the backing memory, and the miss then
// reads the line store once more. The next request can be taken in the cycle
// after the result register is loaded, so a read holds the block until its
// result is loaded, including any wait for a result register still held by
// out_stall. in_stall is low only while the controller is idle; the result
// register lets a new request in while the previous result still waits on
// out_stall. Lines start invalid after reset, so the first read of every
// line misses. Reading a backing byte that was never loaded gives an
// undefined byte. miss_penalty (address 0, reset 10) is added to the time
// count on each miss; write it only while the block is idle.
module direct_mapped_cache_read (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  dmc_pkg::dmc_in_t           in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output dmc_pkg::dmc_out_t          out_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dmc_pkg::APB_AW-1:0] paddr,
  input  logic [dmc_pkg::APB_DW-1:0] pwdata,
  output logic [dmc_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import dmc_pkg::*;

  dmc_cmd_t cmd;
  dmc_sts_t sts;

  // Sequence each request: lookup, optional fill, line read, result
  dmc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold memories, tags, counters, the penalty register and the result
  dmc_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
